/* rtl/core/smalu_pkg.sv */
`default_nettype none

package smalu_pkg;

    // word layout
    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = WORD_BITS - 1;
    localparam int CNT_BITS  = $clog2(MAG_BITS + 1);

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // request payload
    typedef struct packed {
        logic [1:0]           action;
        logic [WORD_BITS-1:0] operand_a;
        logic [WORD_BITS-1:0] operand_b;
    } req_t;

    // result payload
    typedef struct packed {
        logic [WORD_BITS-1:0] result_word;
        logic                 overflow;
        logic                 divide_by_zero;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic iterate;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/core/smalu_ctrl.sv */
`default_nettype none

module smalu_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire smalu_pkg::stat_t stat,
    output logic                busy,
    output smalu_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_DISPATCH = 2'd1;
    localparam logic [1:0] S_EXEC     = 2'd2;
    localparam logic [1:0] S_FINISH   = 2'd3;

    localparam logic [smalu_pkg::CNT_BITS-1:0] LAST_STEP =
        smalu_pkg::CNT_BITS'(smalu_pkg::MAG_BITS - 1);

    logic [1:0]                    state_reg, state_next;
    logic [smalu_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;

    assign busy = (state_reg != S_IDLE);

    // command decode
    always_comb
    begin
        cmd.load   = start && !busy;
        cmd.step   = (state_reg == S_EXEC);
        cmd.finish = (state_reg == S_FINISH);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cnt_next   = '0;
                state_next = stat.iterate ? S_EXEC : S_FINISH;
            end
            S_EXEC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/smalu_dp.sv */
`default_nettype none

module smalu_dp
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire smalu_pkg::req_t request,
    input  wire smalu_pkg::cmd_t cmd,
    output smalu_pkg::stat_t    stat,
    output logic                done,
    output smalu_pkg::rsp_t     result
);

    localparam int MB = smalu_pkg::MAG_BITS;

    // operand registers
    logic [1:0]    op_reg;
    logic          sa_reg, sb_reg;
    logic [MB-1:0] ma_reg, mb_reg;

    // shared shift registers: product high / remainder, product low / quotient
    logic [MB-1:0] hi_reg, hi_next;
    logic [MB-1:0] lo_reg, lo_next;

    smalu_pkg::rsp_t rsp_reg, rsp_next;
    logic            done_reg;

    logic          div_zero;
    logic [MB:0]   mul_sum;
    logic [MB:0]   rem_shift;
    logic [MB+1:0] div_diff;

    assign div_zero     = (mb_reg == '0);
    assign stat.iterate = (op_reg == smalu_pkg::OP_MUL) ||
                          ((op_reg == smalu_pkg::OP_DIV) && !div_zero);

    // one shift-add or shift-subtract step
    assign mul_sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, ma_reg} : '0);
    assign rem_shift = {hi_reg, lo_reg[MB-1]};
    assign div_diff  = {1'b0, rem_shift} - {2'b00, mb_reg};

    always_comb
    begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (cmd.load)
        begin
            hi_next = '0;
            lo_next = (request.action == smalu_pkg::OP_MUL) ?
                      request.operand_b[MB-1:0] : request.operand_a[MB-1:0];
        end
        else if (cmd.step)
        begin
            if (op_reg == smalu_pkg::OP_MUL)
            begin
                hi_next = mul_sum[MB:1];
                lo_next = {mul_sum[0], lo_reg[MB-1:1]};
            end
            else if (!div_diff[MB+1])
            begin
                hi_next = div_diff[MB-1:0];
                lo_next = {lo_reg[MB-2:0], 1'b1};
            end
            else
            begin
                hi_next = rem_shift[MB-1:0];
                lo_next = {lo_reg[MB-2:0], 1'b0};
            end
        end
    end

    // pack sign and magnitude, zero always positive
    function automatic logic [smalu_pkg::WORD_BITS-1:0] pack_word(
        input logic          sign,
        input logic [MB-1:0] mag
    );
        pack_word = (mag == '0) ? '0 : {sign, mag};
    endfunction

    // final result
    always_comb
    begin
        logic          eb;
        logic [MB:0]   sum;
        logic [MB:0]   diff_ab;
        logic [MB-1:0] diff_ba;
        eb      = (op_reg == smalu_pkg::OP_SUB) ? !sb_reg : sb_reg;
        sum     = {1'b0, ma_reg} + {1'b0, mb_reg};
        diff_ab = {1'b0, ma_reg} - {1'b0, mb_reg};
        diff_ba = mb_reg - ma_reg;
        rsp_next = '0;
        case (op_reg) inside
            smalu_pkg::OP_ADD, smalu_pkg::OP_SUB:
            begin
                if (sa_reg == eb)
                begin
                    rsp_next.overflow    = sum[MB];
                    rsp_next.result_word = pack_word(sa_reg, sum[MB-1:0]);
                end
                else if (!diff_ab[MB])
                begin
                    rsp_next.result_word = pack_word(sa_reg, diff_ab[MB-1:0]);
                end
                else
                begin
                    rsp_next.result_word = pack_word(eb, diff_ba);
                end
            end
            smalu_pkg::OP_MUL:
            begin
                rsp_next.overflow    = |hi_reg;
                rsp_next.result_word = pack_word(sa_reg ^ sb_reg, lo_reg);
            end
            default:
            begin
                if (div_zero)
                begin
                    rsp_next.divide_by_zero = 1'b1;
                end
                else
                begin
                    rsp_next.result_word = pack_word(sa_reg ^ sb_reg, lo_reg);
                end
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= request.action;
            sa_reg <= request.operand_a[MB];
            sb_reg <= request.operand_b[MB];
            ma_reg <= request.operand_a[MB-1:0];
            mb_reg <= request.operand_b[MB-1:0];
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

`default_nettype wire

/* rtl/core/sign_magnitude_alu_top.sv */
// sequence: an accepted request passes through the dispatch and finish states for add,
//   subtract and divide by zero; multiply and divide add 31 shift steps, one per bit
// requests: a new request is taken only while idle, once the last one is finished;
//   busy drops in the cycle done is high
// reset: rst_n asynchronous active low clears the controller and the done strobe
// done marks the result for one cycle; the receiver cannot stall it
`default_nettype none

module sign_magnitude_alu_top
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire smalu_pkg::req_t request,
    output logic                done,
    output smalu_pkg::rsp_t     result
);

    smalu_pkg::cmd_t  cmd;
    smalu_pkg::stat_t stat;

    // sequencer
    smalu_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // arithmetic datapath
    smalu_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire
